// ===== rtl/dn40ct_pkg.sv =====
// Shared types and constants for the DN40 colour temperature pipeline.
// No dependencies; used by every module under rtl.
package dn40ct_pkg;

    // Field widths
    localparam int CHAN_W = 16;
    localparam int ATIME_W = 8;
    localparam int KELVIN_W = 28;
    localparam int STATUS_W = 2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SATURATED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RED_ZERO = 2'd2;

    // Saturation level: full scale above this many cycles
    localparam logic [8:0] SAT_CYCLES_MAX = 9'd63;
    localparam logic [CHAN_W-1:0] SAT_FULL = 16'hFFFF;

    // cct = KELVIN_SCALE * b2 / r2 + KELVIN_OFFSET
    localparam logic [11:0] KELVIN_SCALE = 12'd3810;
    localparam logic [KELVIN_W-1:0] KELVIN_OFFSET = 28'd1391;

    // Divider: one quotient bit per step, DIV_STEPS steps per stage
    localparam int DIV_STEPS = 4;
    localparam int DIV_STAGES = KELVIN_W / DIV_STEPS;

    // Divider item: word holds the numerator bits still to go (top) and
    // the quotient bits found so far (bottom)
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CHAN_W-1:0]   divisor;
        logic [CHAN_W-1:0]   rem;
        logic [KELVIN_W-1:0] word;
    } div_t;

endpackage

// ===== rtl/dn40ct_front.sv =====
// Front end: saturation check, IR inference, compensation and scaling.
// Two register stages; depends on dn40ct_pkg.
module dn40ct_front
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             adv,
    input  logic                             in_valid,
    input  logic [dn40ct_pkg::CHAN_W-1:0]    red,
    input  logic [dn40ct_pkg::CHAN_W-1:0]    green,
    input  logic [dn40ct_pkg::CHAN_W-1:0]    blue,
    input  logic [dn40ct_pkg::CHAN_W-1:0]    clear,
    input  logic [dn40ct_pkg::ATIME_W-1:0]   atime,
    output logic                             out_valid,
    output dn40ct_pkg::div_t                 out_item
);

    logic [8:0]                       cycles;
    logic [5:0]                       cyc6;
    logic [dn40ct_pkg::CHAN_W-1:0]    level;
    logic [17:0]                      sum;
    logic [17:0]                      excess;
    logic [dn40ct_pkg::CHAN_W-1:0]    ir;

    logic                             s1_valid_reg;
    logic                             s1_sat_reg;
    logic [dn40ct_pkg::CHAN_W-1:0]    s1_red_reg;
    logic [dn40ct_pkg::CHAN_W-1:0]    s1_blue_reg;
    logic [dn40ct_pkg::CHAN_W-1:0]    s1_ir_reg;

    logic [dn40ct_pkg::CHAN_W-1:0]    r2;
    logic [dn40ct_pkg::CHAN_W-1:0]    b2;
    dn40ct_pkg::div_t                 s2_next;
    logic                             s2_valid_reg;
    dn40ct_pkg::div_t                 s2_reg;

    // Stage 1: saturation level and inferred IR
    always_comb
    begin
        cycles = 9'd256 - {1'b0, atime};
        cyc6   = cycles[5:0];
        if (cycles > dn40ct_pkg::SAT_CYCLES_MAX)
            level = dn40ct_pkg::SAT_FULL;
        else
            level = 16'({cyc6, 9'b0}) + 16'({cyc6, 8'b0}); // 768 * cycles
        sum    = 18'(red) + 18'(green) + 18'(blue);
        excess = sum - 18'(clear);
        ir     = (sum > 18'(clear)) ? excess[16:1] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (adv)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_sat_reg  <= (clear >= level);
            s1_red_reg  <= red;
            s1_blue_reg <= blue;
            s1_ir_reg   <= ir;
        end
    end

    // Stage 2: compensate with 16-bit wrap, scale blue
    always_comb
    begin
        r2 = s1_red_reg - s1_ir_reg;
        b2 = s1_blue_reg - s1_ir_reg;
        s2_next.rem     = '0;
        s2_next.divisor = r2;
        s2_next.word    = 28'(b2) * 28'(dn40ct_pkg::KELVIN_SCALE);
        if (s1_sat_reg)
            s2_next.status = dn40ct_pkg::ST_SATURATED;
        else if (r2 == '0)
            s2_next.status = dn40ct_pkg::ST_RED_ZERO;
        else
            s2_next.status = dn40ct_pkg::ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (adv)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            s2_reg <= s2_next;
    end

    assign out_valid = s2_valid_reg;
    assign out_item  = s2_reg;

endmodule

// ===== rtl/dn40ct_div_stage.sv =====
// One stage of the pipelined restoring divider: DIV_STEPS quotient bits.
// Depends on dn40ct_pkg.
module dn40ct_div_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              in_valid,
    input  dn40ct_pkg::div_t  in_item,
    output logic              out_valid,
    output dn40ct_pkg::div_t  out_item
);

    logic [dn40ct_pkg::CHAN_W-1:0]    rem_v;
    logic [dn40ct_pkg::KELVIN_W-1:0]  word_v;
    logic [dn40ct_pkg::CHAN_W:0]      trial;
    logic [dn40ct_pkg::CHAN_W:0]      diff;
    dn40ct_pkg::div_t                 item_next;
    logic                             valid_reg;
    dn40ct_pkg::div_t                 item_reg;

    // Shift in the next numerator bit, subtract where it fits
    always_comb
    begin
        rem_v  = in_item.rem;
        word_v = in_item.word;
        trial  = '0;
        diff   = '0;
        for (int i = 0; i < dn40ct_pkg::DIV_STEPS; i++)
        begin
            trial  = {rem_v, word_v[dn40ct_pkg::KELVIN_W-1]};
            word_v = {word_v[dn40ct_pkg::KELVIN_W-2:0], 1'b0};
            diff   = trial - {1'b0, in_item.divisor};
            if (trial >= {1'b0, in_item.divisor})
            begin
                rem_v     = diff[dn40ct_pkg::CHAN_W-1:0];
                word_v[0] = 1'b1;
            end
            else
                rem_v = trial[dn40ct_pkg::CHAN_W-1:0];
        end
        item_next         = in_item;
        item_next.rem     = rem_v;
        item_next.word    = word_v;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// ===== rtl/dn40_color_temperature.sv =====
// Top level of the DN40 colour temperature block: APB register, pipeline, output stage.
// Depends on dn40ct_pkg, dn40ct_front and dn40ct_div_stage.
//
// One raw red/green/blue/clear sample gives one kelvin/status result. The
// block is a ten-stage pipeline (two front stages, seven divider stages of
// four quotient bits each, one output register) and takes a new item every
// cycle while the output side does not stall; each item passes the front,
// divider and output registers in that order before its result is shown.
// The whole pipeline holds while a result waits to be taken, so sample_ready
// follows the output register. The 28-bit by 16-bit division sets the depth.
// atime (APB address 0, reset 255) should be written only with the pipeline empty.
module dn40_color_temperature
(
    input  logic                               clk,
    input  logic                               rst_n,
    // APB configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [1:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    // Sample channel
    input  logic                               sample_valid,
    output logic                               sample_ready,
    input  logic [dn40ct_pkg::CHAN_W-1:0]      red,
    input  logic [dn40ct_pkg::CHAN_W-1:0]      green,
    input  logic [dn40ct_pkg::CHAN_W-1:0]      blue,
    input  logic [dn40ct_pkg::CHAN_W-1:0]      clear,
    // Result channel
    output logic                               result_valid,
    input  logic                               result_ready,
    output logic [dn40ct_pkg::KELVIN_W-1:0]    kelvin,
    output logic [dn40ct_pkg::STATUS_W-1:0]    status
);

    logic [dn40ct_pkg::ATIME_W-1:0]    atime_reg;
    logic                              adv;
    logic                              valid_chain [dn40ct_pkg::DIV_STAGES+1];
    dn40ct_pkg::div_t                  item_chain  [dn40ct_pkg::DIV_STAGES+1];
    dn40ct_pkg::div_t                  last_item;
    logic                              result_valid_reg;
    logic [dn40ct_pkg::KELVIN_W-1:0]   kelvin_reg;
    logic [dn40ct_pkg::STATUS_W-1:0]   status_reg;

    // Configuration register; writes to any other address are dropped
    assign pready = 1'b1;
    assign prdata = {24'b0, atime_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            atime_reg <= 8'd255;
        else if (psel && penable && pwrite && (paddr == 2'd0))
            atime_reg <= pwdata[dn40ct_pkg::ATIME_W-1:0];
    end

    // Whole pipeline moves unless the output item is held
    assign adv          = !result_valid_reg || result_ready;
    assign sample_ready = adv;

    dn40ct_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (sample_valid),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .clear     (clear),
        .atime     (atime_reg),
        .out_valid (valid_chain[0]),
        .out_item  (item_chain[0])
    );

    // Divider stages
    for (genvar g = 0; g < dn40ct_pkg::DIV_STAGES; g++)
    begin : g_div
        dn40ct_div_stage u_stage
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (valid_chain[g]),
            .in_item   (item_chain[g]),
            .out_valid (valid_chain[g+1]),
            .out_item  (item_chain[g+1])
        );
    end

    assign last_item = item_chain[dn40ct_pkg::DIV_STAGES];

    // Output stage: add offset, zero the result on any fault
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (adv)
            result_valid_reg <= valid_chain[dn40ct_pkg::DIV_STAGES];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            status_reg <= last_item.status;
            if (last_item.status == dn40ct_pkg::ST_OK)
                kelvin_reg <= last_item.word + dn40ct_pkg::KELVIN_OFFSET;
            else
                kelvin_reg <= '0;
        end
    end

    assign result_valid = result_valid_reg;
    assign kelvin       = kelvin_reg;
    assign status       = status_reg;

    // Checks
    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (status != dn40ct_pkg::ST_OK)) |-> (kelvin == '0))
        else $error("kelvin not zero on faulted item");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (status <= dn40ct_pkg::ST_RED_ZERO))
        else $error("undefined status code");

    a_ok_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (status == dn40ct_pkg::ST_OK))
            |-> (kelvin >= dn40ct_pkg::KELVIN_OFFSET))
        else $error("kelvin below offset on good item");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!adv && valid_chain[0]) |=> valid_chain[0])
        else $error("front item lost during stall");

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for dn40_color_temperature: APB atime setup, sample
// and result valid/ready channels, scoreboard against an in-bench predictor.
// Depends on dn40ct_pkg and the dn40_color_temperature RTL.
`timescale 1ns / 1ps

module tb;

    // Local names for the package constants
    localparam int CHAN_W = dn40ct_pkg::CHAN_W;
    localparam int ATIME_W = dn40ct_pkg::ATIME_W;
    localparam int KELVIN_W = dn40ct_pkg::KELVIN_W;
    localparam int STATUS_W = dn40ct_pkg::STATUS_W;
    localparam logic [STATUS_W-1:0] ST_OK = dn40ct_pkg::ST_OK;
    localparam logic [STATUS_W-1:0] ST_SATURATED = dn40ct_pkg::ST_SATURATED;
    localparam logic [STATUS_W-1:0] ST_RED_ZERO = dn40ct_pkg::ST_RED_ZERO;
    localparam logic [8:0] SAT_CYCLES_MAX = dn40ct_pkg::SAT_CYCLES_MAX;
    localparam logic [CHAN_W-1:0] SAT_FULL = dn40ct_pkg::SAT_FULL;
    localparam logic [11:0] KELVIN_SCALE = dn40ct_pkg::KELVIN_SCALE;
    localparam logic [KELVIN_W-1:0] KELVIN_OFFSET = dn40ct_pkg::KELVIN_OFFSET;

    localparam int CLK_HALF = 4;
    localparam int RESET_CYCLES = 10;
    localparam int CYCLE_LIMIT = 400000;
    localparam int IDLE_PCT = 17;
    localparam int HOLD_CYCLES = 200;
    localparam int DRAIN_CYCLES = 30;
    localparam int RAND_PHASES = 10;
    localparam int PHASE_ITEMS = 55;
    localparam int FULL_CYCLES = 256;
    localparam int SAT_STEP = 1024;
    localparam int NUM_DIRECTED = 20;
    localparam logic [1:0] ATIME_ADDR = 2'd0;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] clear;
    } rgbc_t;

    typedef struct packed {
        logic [KELVIN_W-1:0] kelvin;
        logic [STATUS_W-1:0] status;
    } cct_t;

    // Directed row: result typed in only where it is obvious
    typedef struct {
        logic [ATIME_W-1:0]  at;
        logic [CHAN_W-1:0]   r;
        logic [CHAN_W-1:0]   g;
        logic [CHAN_W-1:0]   b;
        logic [CHAN_W-1:0]   c;
        bit                  typed;
        logic [KELVIN_W-1:0] k;
        logic [STATUS_W-1:0] st;
    } dir_row_t;

    dir_row_t directed_rows [NUM_DIRECTED] = '{
        // reset timing (atime 255): clear saturates at 768
        '{8'd255, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1, 28'd0, ST_RED_ZERO},
        '{8'd255, 16'd0, 16'd0, 16'd0, 16'd768, 1'b1, 28'd0, ST_SATURATED},
        '{8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 28'd0, ST_SATURATED},
        '{8'd255, 16'd1, 16'd0, 16'd0, 16'd767, 1'b1, 28'd1391, ST_OK},
        // IR exactly cancels red
        '{8'd255, 16'd100, 16'd100, 16'd100, 16'd100, 1'b1, 28'd0, ST_RED_ZERO},
        // red' = 1, blue' wraps to all ones: largest kelvin
        '{8'd255, 16'd11, 16'd0, 16'd9, 16'd0, 1'b1, 28'd249689741, ST_OK},
        '{8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 1'b0, 28'd0, ST_OK},
        '{8'd255, 16'd0, 16'd0, 16'hFFFF, 16'd767, 1'b0, 28'd0, ST_OK},
        '{8'd255, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h0155, 1'b0, 28'd0, ST_OK},
        '{8'd255, 16'h5555, 16'hAAAA, 16'h5555, 16'h02AA, 1'b0, 28'd0, ST_OK},
        // atime 254: level 1536
        '{8'd254, 16'd0, 16'd0, 16'd0, 16'd1536, 1'b1, 28'd0, ST_SATURATED},
        '{8'd254, 16'd0, 16'd0, 16'd0, 16'd1535, 1'b1, 28'd0, ST_RED_ZERO},
        // atime 193: last scaled level, 48384
        '{8'd193, 16'd0, 16'd0, 16'd0, 16'd48384, 1'b1, 28'd0, ST_SATURATED},
        '{8'd193, 16'd1, 16'd0, 16'd0, 16'd48383, 1'b1, 28'd1391, ST_OK},
        '{8'd193, 16'hFFFF, 16'd0, 16'd0, 16'd48383, 1'b0, 28'd0, ST_OK},
        // atime 192: full scale
        '{8'd192, 16'd0, 16'd0, 16'd0, 16'd65534, 1'b1, 28'd0, ST_RED_ZERO},
        '{8'd192, 16'd0, 16'd0, 16'd0, 16'hFFFF, 1'b1, 28'd0, ST_SATURATED},
        '{8'd192, 16'd1, 16'd0, 16'd65534, 16'd65534, 1'b0, 28'd0, ST_OK},
        // atime 0: full scale
        '{8'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd65534, 1'b0, 28'd0, ST_OK},
        '{8'd0, 16'd40000, 16'd30000, 16'd20000, 16'd1000, 1'b0, 28'd0, ST_OK}
    };

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [1:0]          paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;
    logic                sample_valid = 1'b0;
    logic                sample_ready;
    logic [CHAN_W-1:0]   red = '0;
    logic [CHAN_W-1:0]   green = '0;
    logic [CHAN_W-1:0]   blue = '0;
    logic [CHAN_W-1:0]   clear = '0;
    logic                result_valid;
    logic                result_ready = 1'b0;
    logic [KELVIN_W-1:0] kelvin;
    logic [STATUS_W-1:0] status;

    cct_t               cct_pending [$];
    logic [ATIME_W-1:0] cur_atime = 8'd255;
    int                 mismatches = 0;
    int                 cycle_count = 0;
    bit                 idle_on = 1'b1;
    bit                 hold_pending = 1'b0;

    dn40_color_temperature dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .clear        (clear),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .kelvin       (kelvin),
        .status       (status)
    );

    always #CLK_HALF clk = ~clk;

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Clear saturation level for a given timing register
    function automatic int unsigned sat_level(logic [ATIME_W-1:0] at);
        int unsigned cycles;
        cycles = FULL_CYCLES - at;
        if (cycles > SAT_CYCLES_MAX)
            return 32'(SAT_FULL);
        return SAT_STEP * cycles - (SAT_STEP * cycles) / 4;
    endfunction

    // Colour temperature with IR removed, as the block should produce it
    function automatic cct_t predict_cct(rgbc_t s, logic [ATIME_W-1:0] at);
        int unsigned       sum;
        logic [CHAN_W-1:0] ir;
        logic [CHAN_W-1:0] r2;
        logic [CHAN_W-1:0] b2;
        longint unsigned   quot;
        cct_t              res;
        res.kelvin = '0;
        if (s.clear >= sat_level(at))
        begin
            res.status = ST_SATURATED;
            return res;
        end
        sum = 32'(s.red) + 32'(s.green) + 32'(s.blue);
        ir = (sum > s.clear) ? CHAN_W'((sum - s.clear) >> 1) : '0;
        r2 = s.red - ir;
        b2 = s.blue - ir;
        if (r2 == '0)
        begin
            res.status = ST_RED_ZERO;
            return res;
        end
        quot = longint'(KELVIN_SCALE) * b2 / r2 + KELVIN_OFFSET;
        res.kelvin = KELVIN_W'(quot);
        res.status = ST_OK;
        return res;
    endfunction

    // Random sample, mostly below the saturation level
    function automatic rgbc_t random_sample(int unsigned level);
        int unsigned kind;
        int unsigned d;
        int unsigned t;
        int unsigned g_lo;
        int unsigned g_hi;
        rgbc_t       s;
        kind = $urandom_range(99);
        s = rgbc_t'({$urandom, $urandom});
        if (kind < 15)
            return s;
        if (kind < 30)
        begin
            // straddle the saturation edge
            t = level + $urandom_range(3);
            s.clear = (t < 2) ? CHAN_W'(0) : (t - 2 > 65535) ? CHAN_W'(65535) : CHAN_W'(t - 2);
        end
        else if (kind < 50)
        begin
            // red' of zero or one; one gives the large quotients
            d = $urandom_range(1, 20000);
            s.clear = CHAN_W'($urandom_range(0, level - 1));
            t = s.clear + d;
            g_lo = (t > 65535) ? t - 65535 : 0;
            g_hi = (t < 65535) ? t : 65535;
            s.green = CHAN_W'($urandom_range(g_lo, g_hi));
            s.blue = CHAN_W'(t - s.green);
            s.red = CHAN_W'(d + $urandom_range(1));
        end
        else if (kind < 65)
        begin
            s.red = CHAN_W'($urandom_range(1023));
            s.green = CHAN_W'($urandom_range(1023));
            s.blue = CHAN_W'($urandom_range(1023));
            s.clear = CHAN_W'($urandom_range(0, (level < 1024) ? level - 1 : 1023));
        end
        else
            s.clear = CHAN_W'($urandom_range(0, level - 1));
        return s;
    endfunction

    // Offer one item and hold it until taken; expectation queued on acceptance
    task automatic offer_sample(rgbc_t s, cct_t want);
        while (idle_on && $urandom_range(99) < IDLE_PCT)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        red <= s.red;
        green <= s.green;
        blue <= s.blue;
        clear <= s.clear;
        do
            @(posedge clk);
        while (!sample_ready);
        cct_pending.push_back(want);
    endtask

    // Stop offering and wait for every outstanding result
    task automatic drain_results();
        sample_valid <= 1'b0;
        while (cct_pending.size() != 0)
            @(posedge clk);
    endtask

    // APB write of atime followed by a read back
    task automatic write_atime(logic [ATIME_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ATIME_ADDR;
        pwdata <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        cur_atime = value;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== 32'(value))
        begin
            $error("prdata: expected %0d, got %0d", value, prdata);
            mismatches++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Result side: random stalls, one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            result_ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
        end
    end

    // Scoreboard: each result against the oldest expectation
    always @(posedge clk)
    begin : check_result
        cct_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (cct_pending.size() == 0)
            begin
                $error("unexpected result: kelvin %0d status %0d", kelvin, status);
                mismatches++;
            end
            else
            begin
                want = cct_pending.pop_front();
                if (kelvin !== want.kelvin)
                begin
                    $error("kelvin: expected %0d, got %0d", want.kelvin, kelvin);
                    mismatches++;
                end
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    mismatches++;
                end
            end
        end
    end

    // Main sequence
    initial
    begin : stimulus
        rgbc_t        s;
        cct_t         want;
        logic [ATIME_W-1:0] at;
        int unsigned  level;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        for (int i = 0; i < NUM_DIRECTED; i++)
        begin
            if (i == 0 || directed_rows[i].at != cur_atime)
            begin
                drain_results();
                write_atime(directed_rows[i].at);
            end
            s = '{directed_rows[i].r, directed_rows[i].g, directed_rows[i].b,
                  directed_rows[i].c};
            if (directed_rows[i].typed)
                want = '{directed_rows[i].k, directed_rows[i].st};
            else
                want = predict_cct(s, cur_atime);
            offer_sample(s, want);
        end

        // Random phases, each with its own timing setting
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            unique case (p)
                0: at = 8'd0;
                1: at = 8'd255;
                2: at = 8'd192;
                3: at = 8'd193;
                4: at = 8'($urandom_range(200, 255));
                default: at = 8'($urandom_range(255));
            endcase
            drain_results();
            write_atime(at);
            idle_on = (p != 5);
            if (p == 2)
                hold_pending = 1'b1;
            level = sat_level(cur_atime);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                s = random_sample(level);
                offer_sample(s, predict_cct(s, cur_atime));
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
